// File: design/lcdst_pkg.sv
// Package with timing constants, opcodes, address decode and shared types for the LCD scan core.
package lcdst_pkg;

  localparam logic [10:0] CYCLES_PER_LINE   = 11'd1232;
  localparam logic [10:0] VISIBLE_CYCLES    = 11'd960;
  localparam logic [10:0] HBLANK_FLAG_CYCLE = 11'd1006;
  localparam logic [7:0]  VISIBLE_LINES     = 8'd160;
  localparam logic [7:0]  TOTAL_LINES       = 8'd228;

  localparam logic [15:0] EN_VBLANK         = 16'h0008;
  localparam logic [15:0] EN_HBLANK         = 16'h0010;
  localparam logic [15:0] EN_MATCH          = 16'h0020;
  localparam logic [15:0] STATUS_WRITE_MASK = EN_VBLANK | EN_HBLANK | EN_MATCH | 16'hFF00;

  localparam logic [31:0] LCD_BASE    = 32'h0400_0000;
  localparam logic [31:0] LCD_LAST    = 32'h0400_0054;
  localparam logic [31:0] STATUS_ADDR = 32'h0400_0004;
  localparam logic [31:0] LINE_ADDR   = 32'h0400_0006;

  localparam logic [5:0] COUNT_MAX = 6'd63;
  localparam int         NUM_RD_REGS = 10;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_WR_STATUS = 2'd1,
    OP_RD_LCD    = 2'd2,
    OP_WR_LCD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } state_t;

  // Result of one event step of the scan timing unit.
  typedef struct packed {
    logic [10:0] position;
    logic [7:0]  line;
    logic [15:0] cycles_left;
    logic        hblank_entry;
    logic        on_visible;
    logic        vblank_entry;
    logic        line_match;
  } step_res_t;

  // Readable register slot for an offset within the LCD window.
  typedef struct packed {
    logic       readable;
    logic [3:0] slot;
  } rd_slot_t;

  function automatic logic addr_is_lcd(input logic [31:0] a);
    return (a[0] == 1'b0) && (a >= LCD_BASE) && (a <= LCD_LAST) &&
           (a != STATUS_ADDR) && (a != LINE_ADDR);
  endfunction

  function automatic logic [15:0] reg_mask(input logic [6:0] off);
    case (off)
      7'h02:        return 16'h0001;
      7'h08, 7'h0A: return 16'hDFFF;
      7'h48, 7'h4A: return 16'h3F3F;
      7'h50:        return 16'h3FFF;
      7'h52:        return 16'h1F1F;
      default:      return 16'hFFFF;
    endcase
  endfunction

  function automatic rd_slot_t rd_slot(input logic [6:0] off);
    rd_slot_t r;
    r.readable = 1'b1;
    case (off)
      7'h00:   r.slot = 4'd0;
      7'h02:   r.slot = 4'd1;
      7'h08:   r.slot = 4'd2;
      7'h0A:   r.slot = 4'd3;
      7'h0C:   r.slot = 4'd4;
      7'h0E:   r.slot = 4'd5;
      7'h48:   r.slot = 4'd6;
      7'h4A:   r.slot = 4'd7;
      7'h50:   r.slot = 4'd8;
      7'h52:   r.slot = 4'd9;
      default: begin
        r.readable = 1'b0;
        r.slot     = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/lcdst_step.sv
// One event step of the scan timing: advance up to the next hblank or line-end event.
module lcdst_step (
  input  logic [7:0]             line,
  input  logic [10:0]            position,
  input  logic [15:0]            cycles_left,
  input  logic [7:0]             match_line,
  output lcdst_pkg::step_res_t   res
);
  import lcdst_pkg::*;

  logic [10:0] next_event;
  logic [10:0] span;
  logic [15:0] step;
  logic [11:0] pos_sum;
  logic [8:0]  line_inc;
  logic [7:0]  line_wrapped;
  logic        wrap;

  always_comb begin
    next_event = (position < VISIBLE_CYCLES) ? VISIBLE_CYCLES : CYCLES_PER_LINE;
    span       = (next_event > position) ? (next_event - position) : 11'd0;
    step       = (cycles_left < {5'd0, span}) ? cycles_left : {5'd0, span};
    pos_sum    = {1'b0, position} + {1'b0, step[10:0]};
    wrap       = (pos_sum >= {1'b0, CYCLES_PER_LINE});
    line_inc   = {1'b0, line} + 9'd1;
    line_wrapped = (line_inc >= {1'b0, TOTAL_LINES}) ? 8'd0 : line_inc[7:0];

    res.cycles_left  = cycles_left - step;
    res.hblank_entry = (pos_sum == {1'b0, VISIBLE_CYCLES}) && (step != 16'd0);
    res.on_visible   = (line < VISIBLE_LINES);
    res.position     = wrap ? 11'd0 : pos_sum[10:0];
    res.line         = wrap ? line_wrapped : line;
    res.vblank_entry = wrap && (line_wrapped == VISIBLE_LINES);
    res.line_match   = wrap && (line_wrapped == match_line);
  end

endmodule

// File: design/lcd_scan_timing_and_status_core.sv
// Top level of the LCD scan timing, status and register file core.
// Timing: a status write or register access goes straight from idle to the done state, whose
// result beat is registered; a tick first passes through the stepping state, one step for every
// hblank or line-end event it crosses or until its cycles run out. One item is in work at a time.
// Reset (rst, synchronous) clears line, position, status control and the LCD registers.
module lcd_scan_timing_and_status_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields from bit 0: cycles[15:0], address[47:16], write_data[63:48]
  input  logic [63:0] s_tdata,
  // s_tuser fields from bit 0: opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields from bit 0: read_data[15:0], read_ok[16], write_ok[17],
  // status_word[33:18], current_line[41:34], cycle_in_line[52:42], hblank_irq[53],
  // vblank_irq[54], match_irq[55], hblank_count[61:56], vblank_count[67:62],
  // match_count[73:68], zero fill[79:74]
  output logic [79:0] m_tdata
);
  import lcdst_pkg::*;

  state_t state, state_next;

  // Architectural state. Only the readable LCD registers are kept, since a write to
  // any other register can never be observed.
  logic [7:0]  line_number;
  logic [10:0] line_position;
  logic [15:0] status_control;
  logic [15:0] lcd_regs [NUM_RD_REGS];

  // Per-item working registers.
  logic [15:0] cycles_left;
  logic [15:0] read_data;
  logic        read_ok, write_ok;
  logic        hblank_irq, vblank_irq, match_irq;
  logic [5:0]  hblank_count, vblank_count, match_count;

  logic        accept;
  op_t         opcode;
  logic [15:0] in_cycles, in_wdata;
  logic [31:0] in_addr;
  logic [6:0]  offset;
  logic        addr_ok;
  rd_slot_t    slot;
  step_res_t   step;
  logic [15:0] status_word;

  assign accept    = s_tvalid && s_tready;
  assign opcode    = op_t'(s_tuser);
  assign in_cycles = s_tdata[15:0];
  assign in_addr   = s_tdata[47:16];
  assign in_wdata  = s_tdata[63:48];
  assign offset    = in_addr[6:0];
  assign addr_ok   = addr_is_lcd(in_addr);
  assign slot      = rd_slot(offset);

  lcdst_step u_step (
    .line        (line_number),
    .position    (line_position),
    .cycles_left (cycles_left),
    .match_line  (status_control[15:8]),
    .res         (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The core takes a new item only when idle and out of reset; a tick with cycles left
  // goes to the stepping state, everything else is finished in the accept cycle.
  always_comb begin
    state_next = state;
    s_tready   = (state == ST_IDLE) && !rst;
    m_tvalid   = (state == ST_DONE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (opcode == OP_TICK && in_cycles != 16'd0) ? ST_TICK : ST_DONE;
        end
      end
      ST_TICK: begin
        if (step.cycles_left == 16'd0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_number    <= 8'd0;
      line_position  <= 11'd0;
      status_control <= 16'd0;
      for (int i = 0; i < NUM_RD_REGS; i++) begin
        lcd_regs[i] <= 16'd0;
      end
    end else begin
      if (accept && opcode == OP_WR_STATUS) begin
        status_control <= in_wdata & STATUS_WRITE_MASK;
      end
      if (accept && opcode == OP_WR_LCD && addr_ok && slot.readable) begin
        lcd_regs[slot.slot] <= in_wdata & reg_mask(offset);
      end
      if (state == ST_TICK) begin
        line_number   <= step.line;
        line_position <= step.position;
      end
    end
  end

  // Per-item result registers: cleared on accept, accumulated while stepping.
  always_ff @(posedge clk) begin
    if (accept) begin
      cycles_left  <= in_cycles;
      read_ok      <= (opcode == OP_RD_LCD) && addr_ok && slot.readable;
      read_data    <= ((opcode == OP_RD_LCD) && addr_ok && slot.readable) ?
                      lcd_regs[slot.slot] : 16'd0;
      write_ok     <= (opcode == OP_WR_LCD) && addr_ok;
      hblank_irq   <= 1'b0;
      vblank_irq   <= 1'b0;
      match_irq    <= 1'b0;
      hblank_count <= 6'd0;
      vblank_count <= 6'd0;
      match_count  <= 6'd0;
    end else if (state == ST_TICK) begin
      cycles_left <= step.cycles_left;
      if (step.hblank_entry) begin
        if (step.on_visible && hblank_count != COUNT_MAX) begin
          hblank_count <= hblank_count + 6'd1;
        end
        if ((status_control & EN_HBLANK) != 16'd0) begin
          hblank_irq <= 1'b1;
        end
      end
      if (step.vblank_entry) begin
        if (vblank_count != COUNT_MAX) begin
          vblank_count <= vblank_count + 6'd1;
        end
        if ((status_control & EN_VBLANK) != 16'd0) begin
          vblank_irq <= 1'b1;
        end
      end
      if (step.line_match) begin
        if (match_count != COUNT_MAX) begin
          match_count <= match_count + 6'd1;
        end
        if ((status_control & EN_MATCH) != 16'd0) begin
          match_irq <= 1'b1;
        end
      end
    end
  end

  // Live status flags: vblank on lines from the first invisible one up to the one before
  // the last, hblank from the flag cycle on, match when the line equals the high byte.
  always_comb begin
    status_word = status_control;
    if (line_number >= VISIBLE_LINES && line_number < TOTAL_LINES - 8'd1) begin
      status_word[0] = 1'b1;
    end
    if (line_position >= HBLANK_FLAG_CYCLE) begin
      status_word[1] = 1'b1;
    end
    if (line_number == status_control[15:8]) begin
      status_word[2] = 1'b1;
    end
  end

  assign m_tdata = {6'd0, match_count, vblank_count, hblank_count,
                    match_irq, vblank_irq, hblank_irq,
                    line_position, line_number, status_word,
                    write_ok, read_ok, read_data};

endmodule
